/* rtl/bbpo_pkg.sv */
package bbpo_pkg;

    // image size, pixels at or beyond these bounds pass through unpainted
    localparam logic [12:0] IMAGE_WIDTH  = 13'd4096;
    localparam logic [12:0] IMAGE_HEIGHT = 13'd4096;

    // coordinate compare width, holds box edge plus or minus thickness
    localparam int CW = 15;

    // configuration register indexes
    localparam logic [2:0] REG_BOX_LEFT       = 3'd0;
    localparam logic [2:0] REG_BOX_TOP        = 3'd1;
    localparam logic [2:0] REG_BOX_RIGHT      = 3'd2;
    localparam logic [2:0] REG_BOX_BOTTOM     = 3'd3;
    localparam logic [2:0] REG_LINE_THICKNESS = 3'd4;
    localparam logic [2:0] REG_CLASS_INDEX    = 3'd5;
    localparam logic [2:0] REG_FILL_MODE      = 3'd6;

    // class colour constants per channel
    localparam logic [7:0] RED_MUL   = 8'd123;
    localparam logic [7:0] RED_ADD   = 8'd50;
    localparam logic [7:0] GREEN_MUL = 8'd231;
    localparam logic [7:0] GREEN_ADD = 8'd100;
    localparam logic [7:0] BLUE_MUL  = 8'd77;
    localparam logic [7:0] BLUE_ADD  = 8'd150;
    localparam logic [7:0] DARK_LIMIT = 8'd64;
    localparam logic [7:0] DARK_LIFT  = 8'd128;

    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       painted;
    } pixel_out_t;

    typedef struct packed {
        logic signed [12:0] box_left;
        logic signed [12:0] box_top;
        logic signed [12:0] box_right;
        logic signed [12:0] box_bottom;
        logic [7:0]         line_thickness;
        logic [9:0]         class_index;
        logic               fill_mode;
    } box_cfg_t;

    // one channel of the class colour, only the low byte of the product matters
    function automatic logic [7:0] class_channel(
        input logic [9:0] class_index,
        input logic [7:0] mul,
        input logic [7:0] add
    );
        logic [15:0] prod;
        logic [7:0]  c;
        prod = {8'd0, class_index[7:0]} * {8'd0, mul};
        c = prod[7:0] + add;
        if (c < DARK_LIMIT)
        begin
            c = c + DARK_LIFT;
        end
        return c;
    endfunction

endpackage

/* rtl/bounding_box_pixel_overlay_core.sv */
// a result passes through the input register and then the result register before it reaches the output
// throughput: one pixel per cycle while out_stall is low, set by the two-register pipeline (input, result)
// a result waiting under out stall holds the pipeline; in_stall rises only when both
// registers are full and the output is stalled
// reset (rst_n low, asynchronous) empties both stages and loads the box registers
// with their reset values: corners 0, thickness 1, class 0, outline mode
module bounding_box_pixel_overlay_core
    import bbpo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // pixel input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  pixel_in_t  in_data,

    // pixel output channel
    output logic       out_valid,
    input  logic       out_stall,
    output pixel_out_t out_data,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    box_cfg_t cfg_reg;
    box_cfg_t cfg_next;

    // writes must arrive only while the pipeline is idle; the block does not enforce this and is always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_LEFT:       cfg_next.box_left       = cfg_data;
                REG_BOX_TOP:        cfg_next.box_top        = cfg_data;
                REG_BOX_RIGHT:      cfg_next.box_right      = cfg_data;
                REG_BOX_BOTTOM:     cfg_next.box_bottom     = cfg_data;
                REG_LINE_THICKNESS: cfg_next.line_thickness = cfg_data[7:0];
                REG_CLASS_INDEX:    cfg_next.class_index    = cfg_data[9:0];
                REG_FILL_MODE:      cfg_next.fill_mode      = cfg_data[0];
                default:            cfg_next = cfg_reg; // index beyond the list is dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_left       <= '0;
            cfg_reg.box_top        <= '0;
            cfg_reg.box_right      <= '0;
            cfg_reg.box_bottom     <= '0;
            cfg_reg.line_thickness <= 8'd1;
            cfg_reg.class_index    <= '0;
            cfg_reg.fill_mode      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic      s1_valid_reg;
    logic      s1_valid_next;
    pixel_in_t s1_pix_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    pixel_out_t out_data_reg;
    pixel_out_t out_data_next;

    logic out_free;  // result register can take a new value this cycle
    logic s1_free;   // input register can take a new transaction this cycle
    logic s1_move;   // input register hands its pixel to the result register
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_stall = !s1_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pix_reg <= in_data;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // hit test between the input register and the result register
    // ------------------------------------------------------------------
    logic signed [CW-1:0] px, py;
    logic signed [CW-1:0] left, top, right, bottom, thick;
    logic signed [CW-1:0] top_in, bottom_in, left_in, right_in;  // inner band edges
    logic signed [CW-1:0] xl, xr, yt, yb;
    logic in_image;
    logic x_span, y_span;
    logic h_band, v_band;
    logic outline_hit, fill_hit, paint;

    always_comb
    begin
        px     = CW'($signed({3'b000, s1_pix_reg.pix_x}));
        py     = CW'($signed({3'b000, s1_pix_reg.pix_y}));
        left   = CW'(cfg_reg.box_left);
        top    = CW'(cfg_reg.box_top);
        right  = CW'(cfg_reg.box_right);
        bottom = CW'(cfg_reg.box_bottom);
        thick  = CW'($signed({7'd0, cfg_reg.line_thickness}));

        top_in    = top + thick - CW'(1);
        bottom_in = bottom - thick + CW'(1);
        left_in   = left + thick - CW'(1);
        right_in  = right - thick + CW'(1);

        // horizontal edges: top band or bottom band, across the box width
        x_span = (px >= left) && (px <= right);
        y_span = (py >= top) && (py <= bottom);
        h_band = ((py >= top) && (py <= top_in)) || ((py >= bottom_in) && (py <= bottom));
        v_band = ((px >= left) && (px <= left_in)) || ((px >= right_in) && (px <= right));
        outline_hit = (cfg_reg.line_thickness != 8'd0) &&
                      ((x_span && h_band) || (y_span && v_band));

        // fill mode orders the corners first
        xl = (left < right) ? left : right;
        xr = (left < right) ? right : left;
        yt = (top < bottom) ? top : bottom;
        yb = (top < bottom) ? bottom : top;
        fill_hit = (px >= xl) && (px <= xr) && (py >= yt) && (py <= yb);

        in_image = ({1'b0, s1_pix_reg.pix_x} < IMAGE_WIDTH) &&
                   ({1'b0, s1_pix_reg.pix_y} < IMAGE_HEIGHT);
        paint = in_image && (cfg_reg.fill_mode ? fill_hit : outline_hit);

        if (paint)
        begin
            out_data_next.out_red   = class_channel(cfg_reg.class_index, RED_MUL, RED_ADD);
            out_data_next.out_green = class_channel(cfg_reg.class_index, GREEN_MUL, GREEN_ADD);
            out_data_next.out_blue  = class_channel(cfg_reg.class_index, BLUE_MUL, BLUE_ADD);
            out_data_next.painted   = 1'b1;
        end
        else
        begin
            out_data_next.out_red   = s1_pix_reg.in_red;
            out_data_next.out_green = s1_pix_reg.in_green;
            out_data_next.out_blue  = s1_pix_reg.in_blue;
            out_data_next.painted   = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the class colour never falls in the dark range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.painted |->
            (out_data.out_red >= DARK_LIMIT) && (out_data.out_green >= DARK_LIMIT) &&
            (out_data.out_blue >= DARK_LIMIT))
        else $error("painted transaction carries a dark class colour");

    // input stalls only when both stages are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid && out_stall)
        else $error("input stalled while the pipeline has room");

    // a pixel leaving the input register shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid)
        else $error("transaction lost between input and result registers");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !s1_valid_reg |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule

/* sim/tb_bounding_box_pixel_overlay_core.sv */
module tb_bounding_box_pixel_overlay_core;
    import bbpo_pkg::*;

    // pipeline depth quoted at the head of the core
    localparam int LATENCY = 2;
    // cycles with no transaction on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 1000;
    // pixels per random phase, twelve phases give about 1500 pixels
    localparam int PHASE_PIXELS = 125;
    localparam int PHASES = 12;
    // an index past the register list, writes to it must change nothing
    localparam logic [2:0] REG_SPARE = 3'd7;

    // mirror of the box registers plus the queue of pixels still owed by the core
    class overlay_scoreboard;
        int left_x;
        int top_y;
        int right_x;
        int bottom_y;
        int thickness;
        int class_num;
        bit fill;
        pixel_out_t owed_q[$];
        int checked;
        int errors;

        function new();
            left_x = 0;
            top_y = 0;
            right_x = 0;
            bottom_y = 0;
            thickness = 1;
            class_num = 0;
            fill = 1'b0;
            checked = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [12:0] data);
            logic signed [12:0] coord;
            coord = data;
            case (index)
                REG_BOX_LEFT:       left_x = coord;
                REG_BOX_TOP:        top_y = coord;
                REG_BOX_RIGHT:      right_x = coord;
                REG_BOX_BOTTOM:     bottom_y = coord;
                REG_LINE_THICKNESS: thickness = data[7:0];
                REG_CLASS_INDEX:    class_num = data[9:0];
                REG_FILL_MODE:      fill = data[0];
                default:            ;
            endcase
        endfunction

        function logic [7:0] shade(int mul, int add);
            int c;
            c = (class_num * mul + add) % 256;
            if (c < int'(DARK_LIMIT))
            begin
                c = c + int'(DARK_LIFT);
            end
            return c[7:0];
        endfunction

        function bit on_box(int x, int y);
            int xl;
            int xr;
            int yt;
            int yb;
            int t;
            t = thickness;
            if (fill)
            begin
                xl = (left_x < right_x) ? left_x : right_x;
                xr = (left_x < right_x) ? right_x : left_x;
                yt = (top_y < bottom_y) ? top_y : bottom_y;
                yb = (top_y < bottom_y) ? bottom_y : top_y;
                return x >= xl && x <= xr && y >= yt && y <= yb;
            end
            if (t == 0)
            begin
                return 1'b0;
            end
            if (x >= left_x && x <= right_x &&
                ((y >= top_y && y <= top_y + t - 1) ||
                 (y >= bottom_y - t + 1 && y <= bottom_y)))
            begin
                return 1'b1;
            end
            return y >= top_y && y <= bottom_y &&
                   ((x >= left_x && x <= left_x + t - 1) ||
                    (x >= right_x - t + 1 && x <= right_x));
        endfunction

        function void note_pixel(pixel_in_t p);
            pixel_out_t r;
            int x;
            int y;
            x = p.pix_x;
            y = p.pix_y;
            if (x < int'(IMAGE_WIDTH) && y < int'(IMAGE_HEIGHT) && on_box(x, y))
            begin
                r.out_red   = shade(RED_MUL, RED_ADD);
                r.out_green = shade(GREEN_MUL, GREEN_ADD);
                r.out_blue  = shade(BLUE_MUL, BLUE_ADD);
                r.painted   = 1'b1;
            end
            else
            begin
                r.out_red   = p.in_red;
                r.out_green = p.in_green;
                r.out_blue  = p.in_blue;
                r.painted   = 1'b0;
            end
            owed_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("pixel result %0d arrived with nothing pending", checked));
                checked++;
                return;
            end
            want = owed_q.pop_front();
            if (got.out_red !== want.out_red)
                report($sformatf("pixel %0d out_red got %0d expected %0d",
                                 checked, got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report($sformatf("pixel %0d out_green got %0d expected %0d",
                                 checked, got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report($sformatf("pixel %0d out_blue got %0d expected %0d",
                                 checked, got.out_blue, want.out_blue));
            if (got.painted !== want.painted)
                report($sformatf("pixel %0d painted got %0b expected %0b",
                                 checked, got.painted, want.painted));
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    pixel_in_t   in_data;
    logic        out_valid;
    logic        out_stall;
    pixel_out_t  out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    overlay_scoreboard sb;

    // pixels accepted by the core, counted on the driving side
    int sent;
    // odds of a sender gap before each pixel, 0 turns gaps off
    int gap_odds;
    // last part of the run, no idling on either side
    bit quiet;
    int idle_cycles;

    // box currently programmed, steers the random pixels toward its edges
    int cur_l;
    int cur_t;
    int cur_r;
    int cur_b;
    int cur_th;

    bounding_box_pixel_overlay_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitor: every value read here is the one held before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_pixel(in_data);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_pixel(out_data);
            end
            // watchdog on cycles with no transaction anywhere
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
                (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: %0d cycles without a transaction", idle_cycles);
                    $display("tb_bounding_box_pixel_overlay_core failed");
                    $finish;
                end
            end
        end
    end

    // receiver: random stall bursts, none once the run goes quiet
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // holds cfg_valid high from one write to the next, the caller lowers it
    task write_reg(input logic [2:0] index, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // all seven registers then the spare index, junk fills the unused upper bits
    task apply_box(input int l, input int t, input int r, input int b,
                   input int th, input int cls, input bit fill_on, input bit junk);
        logic [12:0] d;
        cur_l = l;
        cur_t = t;
        cur_r = r;
        cur_b = b;
        cur_th = th;
        write_reg(REG_BOX_LEFT, 13'(l));
        write_reg(REG_BOX_TOP, 13'(t));
        write_reg(REG_BOX_RIGHT, 13'(r));
        write_reg(REG_BOX_BOTTOM, 13'(b));
        d = 13'($urandom);
        d[7:0] = th[7:0];
        if (!junk) d[12:8] = '0;
        write_reg(REG_LINE_THICKNESS, d);
        d = 13'($urandom);
        d[9:0] = cls[9:0];
        if (!junk) d[12:10] = '0;
        write_reg(REG_CLASS_INDEX, d);
        d = 13'($urandom);
        d[0] = fill_on;
        if (!junk) d[12:1] = '0;
        write_reg(REG_FILL_MODE, d);
        write_reg(REG_SPARE, 13'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // sender: optional gap, then hold the transaction until it is taken
    task send_pixel(input pixel_in_t p);
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task send_xy(input int x, input int y, input logic [7:0] r, input logic [7:0] g,
                 input logic [7:0] b);
        pixel_in_t p;
        p.pix_x = x[11:0];
        p.pix_y = y[11:0];
        p.in_red = r;
        p.in_green = g;
        p.in_blue = b;
        send_pixel(p);
    endtask

    // drain every owed pixel, then let the pipeline empty before any register write
    task settle();
        in_valid <= 1'b0;
        while (sb.checked < sent) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // a point on or next to an edge or an inner band boundary
    function automatic int near_edge(int lo_edge, int hi_edge);
        int pick [6];
        pick = '{lo_edge, hi_edge, lo_edge + cur_th - 1, lo_edge + cur_th,
                 hi_edge - cur_th, hi_edge - cur_th + 1};
        return clamp_coord(pick[$urandom_range(0, 5)] + int'($urandom_range(0, 4)) - 2);
    endfunction

    function automatic int between(int a, int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return clamp_coord(lo + int'($urandom % (hi - lo + 1)));
    endfunction

    // most pixels land around the box, the rest anywhere in the image
    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        int x;
        int y;
        if ($urandom_range(0, 9) < 3)
        begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
        end
        else
        begin
            x = $urandom_range(0, 1) ? near_edge(cur_l, cur_r) : between(cur_l, cur_r);
            y = $urandom_range(0, 1) ? near_edge(cur_t, cur_b) : between(cur_t, cur_b);
        end
        p.pix_x = x[11:0];
        p.pix_y = y[11:0];
        p.in_red = 8'($urandom);
        p.in_green = 8'($urandom);
        p.in_blue = 8'($urandom);
        return p;
    endfunction

    task random_box();
        int l;
        int t;
        int r;
        int b;
        int th;
        int swap;
        case ($urandom_range(0, 9))
            0:
            begin
                // widest box the registers hold
                l = -4096;
                t = -4096;
                r = 4095;
                b = 4095;
            end
            1:
            begin
                l = int'($urandom_range(0, 8191)) - 4096;
                t = int'($urandom_range(0, 8191)) - 4096;
                r = int'($urandom_range(0, 8191)) - 4096;
                b = int'($urandom_range(0, 8191)) - 4096;
            end
            default:
            begin
                l = $urandom_range(0, 4050);
                r = l + int'($urandom_range(0, 40));
                t = $urandom_range(0, 4050);
                b = t + int'($urandom_range(0, 40));
                // inverted corners now and then
                if ($urandom_range(0, 5) == 0)
                begin
                    swap = l;
                    l = r;
                    r = swap;
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    swap = t;
                    t = b;
                    b = swap;
                end
            end
        endcase
        case ($urandom_range(0, 9))
            0:       th = 0;
            1:       th = 255;
            2:       th = $urandom_range(0, 255);
            default: th = $urandom_range(1, 6);
        endcase
        apply_box(l, t, r, b, th, $urandom_range(0, 1023), $urandom_range(0, 2) == 0, 1'b1);
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        gap_odds = 4;
        quiet = 1'b0;
        idle_cycles = 0;
        cur_l = 0;
        cur_t = 0;
        cur_r = 0;
        cur_b = 0;
        cur_th = 1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BOX_LEFT;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box: a single pixel at the origin, class 0 colour
        send_xy(0, 0, 8'hff, 8'h00, 8'haa);
        send_xy(1, 0, 8'h00, 8'hff, 8'h55);
        send_xy(0, 1, 8'h12, 8'h34, 8'h56);
        send_xy(4095, 4095, 8'hff, 8'hff, 8'hff);

        // outline three pixels thick, hits at each band boundary, misses beside the left, right and top inner bands
        settle();
        apply_box(10, 20, 100, 200, 3, 1023, 1'b0, 1'b0);
        send_xy(10, 20, 8'h00, 8'h00, 8'h00);
        send_xy(100, 200, 8'hff, 8'hff, 8'hff);
        send_xy(12, 50, 8'h01, 8'h02, 8'h03);
        send_xy(13, 50, 8'h04, 8'h05, 8'h06);
        send_xy(98, 50, 8'h07, 8'h08, 8'h09);
        send_xy(97, 50, 8'h0a, 8'h0b, 8'h0c);
        send_xy(50, 22, 8'h0d, 8'h0e, 8'h0f);
        send_xy(50, 23, 8'h10, 8'h11, 8'h12);
        send_xy(50, 198, 8'h13, 8'h14, 8'h15);
        send_xy(101, 200, 8'h16, 8'h17, 8'h18);

        // zero thickness draws nothing
        settle();
        apply_box(10, 20, 100, 200, 0, 5, 1'b0, 1'b0);
        send_xy(10, 20, 8'h80, 8'h40, 8'h20);

        // inverted corners in outline mode leave no edge at all
        settle();
        apply_box(100, 200, 10, 20, 2, 7, 1'b0, 1'b0);
        send_xy(100, 100, 8'h21, 8'h22, 8'h23);
        send_xy(50, 200, 8'h24, 8'h25, 8'h26);

        // same corners in fill mode are put in order first
        settle();
        apply_box(100, 200, 10, 20, 2, 7, 1'b1, 1'b0);
        send_xy(50, 100, 8'h27, 8'h28, 8'h29);
        send_xy(9, 100, 8'h2a, 8'h2b, 8'h2c);

        // bands thicker than the box reach past the far edge
        settle();
        apply_box(4, 4, 6, 6, 255, 64, 1'b0, 1'b0);
        send_xy(5, 5, 8'h2d, 8'h2e, 8'h2f);
        send_xy(5, 200, 8'h30, 8'h31, 8'h32);
        send_xy(200, 5, 8'h33, 8'h34, 8'h35);

        // register extremes, fill covers the whole image
        settle();
        apply_box(-4096, -4096, 4095, 4095, 255, 1023, 1'b1, 1'b0);
        send_xy(4095, 0, 8'h00, 8'hff, 8'h00);
        send_xy(0, 4095, 8'hff, 8'h00, 8'hff);

        // random phases, sender drains fully before each new box
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            quiet = (phase >= PHASES - 2);
            gap_odds = (phase % 3 == 1) ? 0 : $urandom_range(2, 8);
            random_box();
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                send_pixel(random_pixel());
            end
        end

        in_valid <= 1'b0;
        while (sb.checked < sent) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
        begin
            $display("tb_bounding_box_pixel_overlay_core passed");
        end
        else
        begin
            $display("tb_bounding_box_pixel_overlay_core failed");
        end
        $finish;
    end

endmodule

/* bounding_box_pixel_overlay_core.f */
rtl/bbpo_pkg.sv
rtl/bounding_box_pixel_overlay_core.sv
sim/tb_bounding_box_pixel_overlay_core.sv
